### hw/rtl/asl_pkg.sv
// Shared types and constants for the append-log setting store.
package asl_pkg;

  localparam int unsigned LogEntriesDef = 256;
  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] ErasedWord     = '1;
  localparam logic [WordW-1:0] DefaultReset   = '0;
  localparam logic [WordW-1:0] ThresholdReset = '1;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgDefault   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_SAVE     = 2'd1,
    KIND_VALIDATE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAVE,
    ST_SCAN,
    ST_WAIT,
    ST_FIX,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic save;
    logic scan;
    logic fix;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic bad;
  } dp_sts_t;

endpackage

### hw/rtl/asl_datapath.sv
// Datapath of the append-log setting store: log memory, fill count and scan compare.
module asl_datapath #(
  parameter int unsigned LOG_ENTRIES = asl_pkg::LogEntriesDef,
  localparam int unsigned AddrW = $clog2(LOG_ENTRIES),
  localparam int unsigned CntW  = $clog2(LOG_ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [asl_pkg::WordW-1:0]    cfg_data_i,
  input  logic [asl_pkg::WordW-1:0]    value_i,
  input  asl_pkg::dp_cmd_t             cmd_i,
  output asl_pkg::dp_sts_t             sts_o,
  output logic [asl_pkg::WordW-1:0]    current_value_o,
  output logic                         log_empty_o,
  output logic                         page_erased_o,
  output logic                         entry_written_o,
  output logic [CntW-1:0]              next_free_o
);
  import asl_pkg::*;

  logic [WordW-1:0] default_q, thr_q;
  logic [WordW-1:0] value_q;
  logic [WordW-1:0] last_q, last_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             cmp_v_q;
  logic             bad_q, bad_d;
  logic             erased_q, erased_d;
  logic             wrote_q, wrote_d;

  logic [WordW-1:0] mem_q [LOG_ENTRIES];
  logic [WordW-1:0] rdata_q;
  logic             we;
  logic [AddrW-1:0] wa;
  logic [WordW-1:0] wd;

  logic val_erased, is_full, dup;

  assign val_erased = (value_q == ErasedWord);
  assign is_full    = (count_q == CntW'(LOG_ENTRIES));
  assign dup        = (count_q != '0) && (last_q == value_q);

  always_comb begin
    count_d  = count_q;
    last_d   = last_q;
    idx_d    = idx_q;
    bad_d    = bad_q;
    erased_d = erased_q;
    wrote_d  = wrote_q;
    we       = 1'b0;
    wa       = count_q[AddrW-1:0];
    wd       = value_q;

    if (cmd_i.load) begin
      erased_d = 1'b0;
      wrote_d  = 1'b0;
      idx_d    = '0;
      bad_d    = 1'b0;
    end

    if (cmd_i.scan) begin
      idx_d = idx_q + AddrW'(1);
    end

    if (cmp_v_q && (rdata_q >= thr_q)) begin
      bad_d = 1'b1;
    end

    if (cmd_i.save && !dup) begin
      wrote_d = 1'b1;
      if (is_full) begin
        // restart the page, the new word (unless all ones) lands at entry zero
        erased_d = 1'b1;
        wa       = '0;
        if (!val_erased) begin
          we      = 1'b1;
          count_d = CntW'(1);
          last_d  = value_q;
        end else begin
          count_d = '0;
        end
      end else if (!val_erased) begin
        we      = 1'b1;
        count_d = count_q + CntW'(1);
        last_d  = value_q;
      end
    end

    if (cmd_i.fix && bad_q) begin
      erased_d = 1'b1;
      wrote_d  = 1'b1;
      wa       = '0;
      wd       = default_q;
      if (default_q != ErasedWord) begin
        we      = 1'b1;
        count_d = CntW'(1);
        last_d  = default_q;
      end else begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= DefaultReset;
      thr_q     <= ThresholdReset;
      count_q   <= '0;
      idx_q     <= '0;
      cmp_v_q   <= 1'b0;
      bad_q     <= 1'b0;
      erased_q  <= 1'b0;
      wrote_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgDefault:   default_q <= cfg_data_i;
          CfgThreshold: thr_q     <= cfg_data_i;
          default:      ;
        endcase
      end
      count_q  <= count_d;
      idx_q    <= idx_d;
      cmp_v_q  <= cmd_i.scan;
      bad_q    <= bad_d;
      erased_q <= erased_d;
      wrote_q  <= wrote_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_last  = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign sts_o.bad        = bad_q;

  assign current_value_o = (count_q == '0) ? default_q : last_q;
  assign log_empty_o     = (count_q == '0);
  assign page_erased_o   = erased_q;
  assign entry_written_o = wrote_q;
  assign next_free_o     = count_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LOG_ENTRIES))
    else $error("fill count beyond page size");

  a_erase_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    erased_q |-> wrote_q)
    else $error("page erased without an entry written");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (CntW'(idx_q) < count_q))
    else $error("scan read beyond written entries");
`endif

endmodule

### hw/rtl/asl_ctrl.sv
// Controller state machine of the append-log setting store.
module asl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        kind_i,
  input  asl_pkg::dp_sts_t  sts_i,
  output asl_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import asl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (kind_i)
            KIND_SAVE:     state_d = ST_SAVE;
            KIND_VALIDATE: state_d = sts_i.count_zero ? ST_RESP : ST_SCAN;
            KIND_READ:     state_d = ST_RESP;
            default:       state_d = ST_RESP;
          endcase
        end
      end
      ST_SAVE: begin
        cmd_o.save = 1'b1;
        state_d    = ST_RESP;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_FIX;
      end
      ST_FIX: begin
        // rewrite the page only when the scan flagged a corrupt word
        cmd_o.fix = sts_i.bad;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !sts_i.count_zero)
    else $error("scan running over an empty log");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");
`endif

endmodule

### hw/rtl/append_log_setting_store.sv
// Top level of the append-log setting store: controller plus datapath.
//
// Keeps a 64-bit setting as an append-only log in one page of LOG_ENTRIES
// words; an erased word is all ones. An operation is taken on a cycle with
// start high and busy low; its single result is shown for exactly one cycle
// with done_o high and cannot be held off, so sample it then. Read returns
// the newest word (default_value if the log is empty), save appends unless
// the value matches the newest word (erasing the page first when full), and
// validate erases and rewrites the default if any stored word is at or above
// the threshold. The validate scan reads one log word per cycle through the
// single memory read port; a new operation is taken the cycle after done_o.
// No clearing pass after reset: a fill count marks which entries are valid.
// Configuration beats (index 0 default_value, index 1 invalid_threshold) are
// always accepted and must only arrive while idle.
module append_log_setting_store #(
  parameter int unsigned LOG_ENTRIES = asl_pkg::LogEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [asl_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [asl_pkg::WordW-1:0]           cfg_data_i,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind_i,
  input  logic [asl_pkg::WordW-1:0]           value_i,
  // result side
  output logic                                done_o,
  output logic [asl_pkg::WordW-1:0]           current_value_o,
  output logic                                log_empty_o,
  output logic                                page_erased_o,
  output logic                                entry_written_o,
  output logic [$clog2(LOG_ENTRIES+1)-1:0]    next_free_o
);
  import asl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // registers take a beat in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  asl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  asl_datapath #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .current_value_o (current_value_o),
    .log_empty_o     (log_empty_o),
    .page_erased_o   (page_erased_o),
    .entry_written_o (entry_written_o),
    .next_free_o     (next_free_o)
  );

endmodule

### dv/tb_append_log_setting_store.sv
// Self-checking testbench for the append-log setting store.
module tb_append_log_setting_store;
  timeunit 1ns;
  timeprecision 1ps;

  import asl_pkg::*;

  localparam int unsigned LogEntries = LogEntriesDef;
  localparam int unsigned NfW        = $clog2(LogEntries + 1);
  // Slowest beat is a validate over a full page, plus the longest sender gap;
  // allow several times that before giving up.
  localparam int unsigned StallLimit = 4000;
  // Kind 3 has no package name; the block treats it as a read.
  localparam logic [1:0]  KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] current_value;
    logic             log_empty;
    logic             page_erased;
    logic             entry_written;
    logic [NfW-1:0]   next_free;
  } status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [WordW-1:0]     cfg_data_i;
  logic                 start;
  logic                 busy;
  logic [1:0]           kind_i;
  logic [WordW-1:0]     value_i;
  logic                 done_o;
  logic [WordW-1:0]     current_value_o;
  logic                 log_empty_o;
  logic                 page_erased_o;
  logic                 entry_written_o;
  logic [NfW-1:0]       next_free_o;

  // Predicted page contents and configuration, kept in step with each beat.
  logic [WordW-1:0]     log_words [LogEntries];
  logic [WordW-1:0]     dflt_word;
  logic [WordW-1:0]     corrupt_floor;

  status_t              pending_status [$];
  int unsigned          fails;
  int unsigned          quiet_cycles;
  int unsigned          burst_left;
  // Mirror of the level last scheduled on start, so it is never driven twice
  // in one time step.
  bit                   start_up;

  append_log_setting_store #(
    .LOG_ENTRIES(LogEntries)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .current_value_o(current_value_o),
    .log_empty_o    (log_empty_o),
    .page_erased_o  (page_erased_o),
    .entry_written_o(entry_written_o),
    .next_free_o    (next_free_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Index of the first erased word; LogEntries when the page is full.
  function automatic int unsigned first_blank();
    for (int unsigned i = 0; i < LogEntries; i++) begin
      if (log_words[i] == ErasedWord) return i;
    end
    return LogEntries;
  endfunction

  // Setting a read would return right now.
  function automatic logic [WordW-1:0] current_setting();
    int unsigned nf;
    nf = first_blank();
    return (nf == 0) ? dflt_word : log_words[nf-1];
  endfunction

  function automatic void wipe_page(input logic [WordW-1:0] w);
    foreach (log_words[i]) log_words[i] = ErasedWord;
    log_words[0] = w;
  endfunction

  // Apply one accepted command to the predicted page and return the status
  // the block must report for it.
  function automatic status_t apply_setting_op(input logic [1:0] k,
                                               input logic [WordW-1:0] v);
    status_t     s;
    int unsigned nf;
    logic        hit;
    s   = '0;
    hit = 1'b0;
    case (k)
      KIND_SAVE: begin
        nf = first_blank();
        // An empty log always takes the save, even of the default.
        if (nf == 0 || log_words[nf-1] != v) begin
          if (nf >= LogEntries) begin
            wipe_page(v);
            s.page_erased = 1'b1;
          end else begin
            log_words[nf] = v;
          end
          s.entry_written = 1'b1;
        end
      end
      KIND_VALIDATE: begin
        foreach (log_words[i]) begin
          if (log_words[i] != ErasedWord && log_words[i] >= corrupt_floor) hit = 1'b1;
        end
        // One erase however many words are corrupt.
        if (hit) begin
          wipe_page(dflt_word);
          s.page_erased   = 1'b1;
          s.entry_written = 1'b1;
        end
      end
      default: ;  // read, and the spare kind behaves as a read
    endcase
    nf = first_blank();
    s.current_value = (nf == 0) ? dflt_word : log_words[nf-1];
    s.log_empty     = (nf == 0);
    s.next_free     = NfW'(nf);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  // Results cannot be held off: take each one on the edge that ends its
  // done cycle and match it against the oldest pending status.
  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $error("result beat with no command pending");
        fails++;
      end else begin
        want = pending_status.pop_front();
        compare_field("current_value", want.current_value, current_value_o);
        compare_field("log_empty", WordW'(want.log_empty), WordW'(log_empty_o));
        compare_field("page_erased", WordW'(want.page_erased), WordW'(page_erased_o));
        compare_field("entry_written", WordW'(want.entry_written),
                      WordW'(entry_written_o));
        compare_field("next_free", WordW'(want.next_free), WordW'(next_free_o));
      end
    end
  end

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic set_start(input bit level);
    if (start_up != level) begin
      start   <= level;
      start_up = level;
    end
  endtask

  // Send one command beat, then either stay in the burst or drop start for a
  // random gap. Most gaps are short; some are long enough to land after the
  // block has gone idle.
  task automatic send_op(input logic [1:0] k, input logic [WordW-1:0] v);
    set_start(1'b1);
    kind_i  <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    pending_status.push_back(apply_setting_op(k, v));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      set_start(1'b0);
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(20, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Hold off the sender until every pending status has come back.
  task automatic wait_idle();
    set_start(1'b0);
    while (pending_status.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write both registers in back-to-back beats while the block is idle.
  task automatic set_config(input logic [WordW-1:0] dflt, input logic [WordW-1:0] thr);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgDefault;
    cfg_data_i  <= dflt;
    do @(posedge clk_i); while (!cfg_ready_o);
    dflt_word = dflt;
    cfg_index_i <= CfgThreshold;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    corrupt_floor = thr;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty-log behaviour: reads and validates report the default, the spare
  // kind reads, and a save of the default into an empty log still programs.
  task automatic test_empty_log();
    logic [WordW-1:0] dflt;
    dflt = 64'hA5A5_5A5A_0F0F_F0F0;
    set_config(dflt, ErasedWord);
    send_op(KIND_READ, rand_word());
    send_op(KIND_SPARE, rand_word());
    send_op(KIND_VALIDATE, rand_word());
    send_op(KIND_SAVE, dflt);
    send_op(KIND_SAVE, dflt);      // same as newest word: no write
    send_op(KIND_SAVE, '0);
    send_op(KIND_READ, '0);
  endtask

  // Saving all ones programs but leaves the entry erased.
  task automatic test_all_ones_save();
    send_op(KIND_SAVE, ErasedWord);
    send_op(KIND_SAVE, ErasedWord);
    send_op(KIND_READ, ErasedWord);
  endtask

  // Validation below and above the threshold, with an all-ones default and
  // with a zero threshold that flags every written word.
  task automatic test_validation();
    set_config(ErasedWord, 64'hC000_0000_0000_0000);
    send_op(KIND_VALIDATE, '0);
    send_op(KIND_SAVE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_op(KIND_VALIDATE, '0);    // hit: page ends empty
    send_op(KIND_READ, '0);
    set_config(rand_word(), '0);
    send_op(KIND_SAVE, rand_word());
    send_op(KIND_SAVE, rand_word());
    send_op(KIND_VALIDATE, rand_word());
    send_op(KIND_VALIDATE, rand_word());
    send_op(KIND_READ, rand_word());
  endtask

  // Fill the page, overflow it, fill again, validate the full page (the slowest
  // command), then overflow with all ones.
  task automatic test_page_wrap();
    logic [WordW-1:0] v;
    set_config(rand_word(), ErasedWord);
    for (int pass = 0; pass < 2; pass++) begin
      while (first_blank() < LogEntries) begin
        v = rand_word();
        if (v == ErasedWord) v = '0;
        send_op(KIND_SAVE, v);
        // Pause once mid-fill until the pipe is empty.
        if (pass == 0 && first_blank() == LogEntries / 2) wait_idle();
      end
      if (pass == 1) send_op(KIND_VALIDATE, '0);
      send_op(KIND_SAVE, (pass == 0) ? rand_word() : ErasedWord);
      send_op(KIND_READ, rand_word());
    end
  endtask

  // Mixed random traffic over several register settings, extremes included.
  task automatic test_random_mix();
    logic [WordW-1:0] dflt;
    logic [WordW-1:0] thr;
    logic [WordW-1:0] v;
    logic [1:0]       k;
    int unsigned      r;
    for (int phase = 0; phase < 5; phase++) begin
      v = rand_word();
      case (phase)
        0:       begin dflt = '0;          thr = ErasedWord;        end
        1:       begin dflt = ErasedWord;  thr = '0;                end
        2:       begin dflt = rand_word(); thr = rand_word();       end
        3:       begin dflt = rand_word(); thr = {2'b11, v[61:0]};  end
        default: begin dflt = 64'(r);      thr = {1'b1, v[62:0]};   end
      endcase
      if (phase == 4) dflt = 64'($urandom_range(0, 255));
      set_config(dflt, thr);
      for (int n = 0; n < 80; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      k = KIND_SAVE;
        else if (r < 70) k = KIND_VALIDATE;
        else if (r < 95) k = KIND_READ;
        else             k = KIND_SPARE;
        // Bias saves towards repeats, all ones, the default and small words.
        r = $urandom_range(0, 99);
        if (k == KIND_SAVE && r < 20)      v = current_setting();
        else if (k == KIND_SAVE && r < 25) v = ErasedWord;
        else if (k == KIND_SAVE && r < 30) v = dflt_word;
        else if (r < 40)                   v = 64'($urandom_range(0, 255));
        else                               v = rand_word();
        send_op(k, v);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    start       = 1'b0;
    start_up    = 1'b0;
    kind_i      = '0;
    value_i     = '0;
    fails       = 0;
    burst_left  = 0;
    foreach (log_words[i]) log_words[i] = ErasedWord;
    dflt_word     = DefaultReset;
    corrupt_floor = ThresholdReset;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_log();
    test_all_ones_save();
    test_validation();
    test_page_wrap();
    test_random_mix();

    // Drain, then wait for any stray result beat.
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
